// ===== rtl/mlfq_pkg.sv =====
// Shared types, constants and helper functions of the feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam int TASKS     = 64;
    localparam int IDX_W     = $clog2(TASKS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int LEVELS    = 4;
    localparam int LVL_W     = 2;
    localparam int LCNT_W    = 3;
    localparam int PID_W     = 8;
    localparam int TIME_W    = 32;
    localparam int LEN_W     = 16;
    localparam int BOOST_W   = 16;
    localparam int TAB_W     = 64;
    localparam int RR_W      = PID_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int CAUSE_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOOST = 2'd0,
        CFG_LEVELS = 2'd1,
        CFG_SLICE = 2'd2,
        CFG_ALLOT = 2'd3
    } t_cfg_idx;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_DONE   = 2'd0,
        CAUSE_KEPT   = 2'd1,
        CAUSE_DEMOTE = 2'd2,
        CAUSE_BOOST  = 2'd3
    } t_cause;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_ARRIVE, ST_PICK, ST_READ, ST_LOAD, ST_SCHK,
        ST_SDIV, ST_END, ST_BCHK, ST_BDIV, ST_BOOST, ST_WRITE, ST_SWEEP
    } t_state;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] arrival;
        logic [LEN_W-1:0]  need;
        logic [LEN_W-1:0]  done;
        logic [LEN_W-1:0]  service;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef struct packed {
        logic accept;
        logic scan_run;
        logic arrive;
        logic pick;
        logic ent_rd;
        logic load;
        logic div_slice;
        logic div_boost;
        logic slice_take;
        logic end_slot;
        logic boost;
        logic write;
        logic sweep;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic scan_done;
        logic run_active;
        logic fin;
        logic slice_nz;
        logic div_busy;
        logic rem_zero;
        logic rec_due;
        logic boost_cand;
        logic boost_flag;
        logic out_free;
        logic sweep_last;
    } t_sts;

    function automatic logic [LVL_W-1:0] top_of(input logic [LCNT_W-1:0] c);
        logic [LVL_W-1:0] t;
        if (c == '0) begin
            t = '0;
        end else if (c > LCNT_W'(LEVELS)) begin
            t = LVL_W'(LEVELS - 1);
        end else begin
            t = LVL_W'(c - LCNT_W'(1));
        end
        return t;
    endfunction

    function automatic logic [LVL_W-1:0] eff_lvl(input logic [LVL_W-1:0] l,
                                                 input logic [LVL_W-1:0] t);
        return (l > t) ? t : l;
    endfunction

endpackage

// ===== rtl/mlfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/mlfq_rem.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor.
`timescale 1ns / 1ps
module mlfq_rem (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mlfq_pkg::TIME_W-1:0]        i_dividend,
    input  logic [mlfq_pkg::BOOST_W-1:0]       i_divisor,
    output logic                               o_busy,
    output logic                               o_zero
);
    import mlfq_pkg::*;

    localparam int STEP_W = $clog2(TIME_W);

    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic [BOOST_W-1:0] r_rem;
    logic [BOOST_W-1:0] r_div;
    logic [TIME_W-1:0]  r_sh;
    logic [BOOST_W:0]   w_trial;

    assign w_trial = {r_rem, r_sh[TIME_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(TIME_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_sh  <= i_dividend;
        end else if (r_busy) begin
            r_sh <= {r_sh[TIME_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= BOOST_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= BOOST_W'(w_trial);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_zero = (r_rem == '0);
endmodule

// ===== rtl/mlfq_ctrl.sv =====
// Sequencer for arrival and tick requests of the feedback queue scheduler.
`timescale 1ns / 1ps
module mlfq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mlfq_pkg::t_sts    i_sts,
    output mlfq_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);
    import mlfq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.is_tick ? ST_PICK : ST_ARRIVE;
                end
            end
            ST_ARRIVE: begin
                o_cmd.arrive = 1'b1;
                n_state = ST_IDLE;
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = ST_READ;
            end
            ST_READ: begin
                if (i_sts.run_active) begin
                    o_cmd.ent_rd = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_BCHK;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = ST_SCHK;
            end
            ST_SCHK: begin
                if (!i_sts.fin && i_sts.slice_nz) begin
                    o_cmd.div_slice = 1'b1;
                    n_state = ST_SDIV;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_SDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.slice_take = 1'b1;
                    n_state = ST_END;
                end
            end
            ST_END: begin
                if (!i_sts.rec_due || i_sts.out_free) begin
                    o_cmd.end_slot = 1'b1;
                    n_state = ST_BCHK;
                end
            end
            ST_BCHK: begin
                if (i_sts.boost_cand) begin
                    o_cmd.div_boost = 1'b1;
                    n_state = ST_BDIV;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_BDIV: begin
                if (!i_sts.div_busy) begin
                    n_state = i_sts.rem_zero ? ST_BOOST : ST_WRITE;
                end
            end
            ST_BOOST: begin
                if (!i_sts.run_active || i_sts.out_free) begin
                    o_cmd.boost = 1'b1;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state = i_sts.boost_flag ? ST_SWEEP : ST_IDLE;
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);
endmodule

// ===== rtl/mlfq_dp.sv =====
// Datapath: task table, scan statistics, selection, slot accounting and record register.
`timescale 1ns / 1ps
module mlfq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mlfq_pkg::t_cmd                      i_cmd,
    output mlfq_pkg::t_sts                      o_sts,
    input  logic                                i_kind,
    input  logic [mlfq_pkg::PID_W-1:0]          i_task_id,
    input  logic [mlfq_pkg::LEN_W-1:0]          i_run_length,
    input  logic                                i_cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mlfq_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [mlfq_pkg::PID_W-1:0]          o_slot_pid,
    output logic [mlfq_pkg::TIME_W-1:0]         o_slot_arrival,
    output logic [mlfq_pkg::TIME_W-1:0]         o_slot_start,
    output logic [mlfq_pkg::TIME_W-1:0]         o_slot_end,
    output logic [mlfq_pkg::LEN_W-1:0]          o_left_to_run,
    output logic [mlfq_pkg::LVL_W-1:0]          o_slot_level,
    output logic [mlfq_pkg::LEN_W-1:0]          o_level_service,
    output logic [mlfq_pkg::CAUSE_W-1:0]        o_end_cause
);
    import mlfq_pkg::*;

    // configuration
    logic [BOOST_W-1:0] r_boost_per;
    logic [LCNT_W-1:0]  r_lvl_cnt;
    logic [TAB_W-1:0]   r_slice_tab;
    logic [TAB_W-1:0]   r_allot_tab;
    logic [LVL_W-1:0]   w_top;

    // request
    logic               r_kind;
    logic [PID_W-1:0]   r_in_pid;
    logic [LEN_W-1:0]   r_in_len;

    // scheduler state
    logic [TASKS-1:0]   r_valid;
    logic [TIME_W-1:0]  r_now;
    logic               r_run_active;
    logic [IDX_W-1:0]   r_run_idx;
    logic [TIME_W-1:0]  r_begin;
    logic [RR_W-1:0]    r_rr [LEVELS];
    logic               r_new_flag;

    // scan
    logic [CNT_W-1:0]   r_cnt;
    logic               r_lag;
    logic [IDX_W-1:0]   r_sidx;
    logic               r_dup;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;
    logic [1:0]         r_lcnt [LEVELS];
    logic               r_low_v [LEVELS];
    logic [PID_W-1:0]   r_low_pid [LEVELS];
    logic [IDX_W-1:0]   r_low_idx [LEVELS];
    logic               r_best_v [LEVELS];
    logic [PID_W-1:0]   r_best_pid [LEVELS];
    logic [IDX_W-1:0]   r_best_idx [LEVELS];

    // running entry
    t_entry             r_ent;
    logic [LVL_W-1:0]   r_ent_lvl;
    logic               r_ent_ld;
    logic               r_fin;
    logic               r_slice_hit;
    logic               r_boost_flag;

    // memories
    t_entry             w_rd_ent;
    logic [ENT_W-1:0]   w_rd_raw;
    logic [LVL_W-1:0]   w_rd_lvl;
    logic [IDX_W-1:0]   w_raddr;
    logic               w_ent_we;
    logic [IDX_W-1:0]   w_ent_waddr;
    t_entry             w_ent_wdata;
    logic               w_lvl_we;
    logic [IDX_W-1:0]   w_lvl_waddr;
    logic [LVL_W-1:0]   w_lvl_wdata;
    logic               w_arrive_ok;

    // derived
    logic [LVL_W-1:0]   w_scan_lvl;
    logic               w_scan_v;
    logic [LEN_W-1:0]   w_slice;
    logic [LEN_W-1:0]   w_allot;
    logic               w_demote;
    logic               w_pick_found;
    logic [LVL_W-1:0]   w_pick_lvl;
    logic [IDX_W-1:0]   w_pick_idx;
    logic               w_div_busy;
    logic               w_rem_zero;
    logic [TIME_W-1:0]  w_dividend;
    logic [BOOST_W-1:0] w_divisor;
    logic               w_out_free;
    logic [RR_W-1:0]    w_rr_next;
    logic               w_rr_upd;

    assign w_top    = top_of(r_lvl_cnt);
    assign w_rd_ent = t_entry'(w_rd_raw);

    assign w_scan_lvl = eff_lvl(w_rd_lvl, w_top);
    assign w_scan_v   = r_valid[r_sidx];

    assign w_slice  = r_slice_tab[LEN_W*r_ent_lvl +: LEN_W];
    assign w_allot  = r_allot_tab[LEN_W*r_ent_lvl +: LEN_W];
    assign w_demote = r_slice_hit && (r_ent.service == w_allot) && (r_ent_lvl != '0);

    assign w_arrive_ok = i_cmd.arrive && !r_dup && r_free_ok;
    assign w_out_free  = !o_out_valid || !i_out_stall;

    assign w_rr_next = RR_W'({1'b0, r_ent.pid} + RR_W'(1));
    always_comb begin
        w_rr_upd = 1'b0;
        if (r_fin) begin
            w_rr_upd = (r_lcnt[r_ent_lvl] == 2'd3);
        end else if (r_slice_hit) begin
            w_rr_upd = w_demote ? (r_lcnt[r_ent_lvl] == 2'd3)
                                : (r_lcnt[r_ent_lvl] >= 2'd2);
        end
    end

    // selection: highest non-empty level, then lowest or round-robin pid
    always_comb begin
        w_pick_found = 1'b0;
        w_pick_lvl   = '0;
        w_pick_idx   = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (LVL_W'(l) <= w_top && r_lcnt[l] != 2'd0) begin
                w_pick_found = 1'b1;
                w_pick_lvl   = LVL_W'(l);
            end
        end
        if (r_lcnt[w_pick_lvl] == 2'd1 || r_new_flag || r_rr[w_pick_lvl][PID_W]
                || !r_best_v[w_pick_lvl]) begin
            w_pick_idx = r_low_idx[w_pick_lvl];
        end else begin
            w_pick_idx = r_best_idx[w_pick_lvl];
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boost_per <= BOOST_W'(100);
            r_lvl_cnt   <= LCNT_W'(LEVELS);
            r_slice_tab <= '0;
            r_allot_tab <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BOOST:  r_boost_per <= i_cfg_data[BOOST_W-1:0];
                CFG_LEVELS: r_lvl_cnt   <= i_cfg_data[LCNT_W-1:0];
                CFG_SLICE:  r_slice_tab <= i_cfg_data[TAB_W-1:0];
                CFG_ALLOT:  r_allot_tab <= i_cfg_data[TAB_W-1:0];
            endcase
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= i_kind;
            r_in_pid <= i_task_id;
            r_in_len <= i_run_length;
        end
    end

    // scan counter and per-level statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_lag <= 1'b0;
        end else if (i_cmd.accept) begin
            r_cnt <= '0;
            r_lag <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_cnt <= r_cnt + CNT_W'(!r_cnt[IDX_W]);
            r_lag <= !r_cnt[IDX_W];
        end else if (i_cmd.write) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dup     <= 1'b0;
            r_free_ok <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_lcnt[l]   <= 2'd0;
                r_low_v[l]  <= 1'b0;
                r_best_v[l] <= 1'b0;
            end
        end else if (i_cmd.scan_run) begin
            r_sidx <= r_cnt[IDX_W-1:0];
            if (r_lag) begin
                if (!w_scan_v && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_sidx;
                end
                if (w_scan_v && w_rd_ent.pid == r_in_pid) begin
                    r_dup <= 1'b1;
                end
                for (int l = 0; l < LEVELS; l++) begin
                    if (w_scan_v && w_scan_lvl == LVL_W'(l)) begin
                        if (r_lcnt[l] != 2'd3) begin
                            r_lcnt[l] <= r_lcnt[l] + 2'd1;
                        end
                        if (!r_low_v[l] || w_rd_ent.pid < r_low_pid[l]) begin
                            r_low_v[l]   <= 1'b1;
                            r_low_pid[l] <= w_rd_ent.pid;
                            r_low_idx[l] <= r_sidx;
                        end
                        if (w_rd_ent.pid >= r_rr[l][PID_W-1:0]
                                && (!r_best_v[l] || w_rd_ent.pid < r_best_pid[l])) begin
                            r_best_v[l]   <= 1'b1;
                            r_best_pid[l] <= w_rd_ent.pid;
                            r_best_idx[l] <= r_sidx;
                        end
                    end
                end
            end
        end
    end

    // scheduler control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_now        <= '0;
            r_run_active <= 1'b0;
            r_run_idx    <= '0;
            r_begin      <= '0;
            r_new_flag   <= 1'b0;
            r_boost_flag <= 1'b0;
            r_ent_ld     <= 1'b0;
            r_fin        <= 1'b0;
            r_slice_hit  <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_rr[l] <= {1'b1, {PID_W{1'b0}}};
            end
        end else begin
            if (i_cmd.accept) begin
                r_boost_flag <= 1'b0;
                r_ent_ld     <= 1'b0;
                r_fin        <= 1'b0;
                r_slice_hit  <= 1'b0;
            end
            if (w_arrive_ok) begin
                r_valid[r_free_idx] <= 1'b1;
                r_new_flag          <= 1'b1;
            end
            if (i_cmd.pick) begin
                r_now <= r_now + TIME_W'(1);
                if (!r_run_active && w_pick_found) begin
                    r_run_active <= 1'b1;
                    r_run_idx    <= w_pick_idx;
                    r_begin      <= r_now;
                    r_new_flag   <= 1'b0;
                end
            end
            if (i_cmd.load) begin
                r_ent_ld <= 1'b1;
                r_fin    <= (w_rd_ent.done + LEN_W'(1)) >= w_rd_ent.need;
            end
            if (i_cmd.slice_take) begin
                r_slice_hit <= w_rem_zero;
            end
            if (i_cmd.end_slot) begin
                if (r_fin || r_slice_hit) begin
                    r_run_active <= 1'b0;
                end
                if (r_fin) begin
                    r_valid[r_run_idx] <= 1'b0;
                end
                if (w_rr_upd) begin
                    r_rr[r_ent_lvl] <= w_rr_next;
                end
            end
            if (i_cmd.boost) begin
                r_boost_flag <= 1'b1;
                r_run_active <= 1'b0;
                for (int l = 0; l < LEVELS; l++) begin
                    r_rr[l] <= {1'b1, {PID_W{1'b0}}};
                end
            end
        end
    end

    // running entry copy
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ent         <= '{pid:     w_rd_ent.pid,
                               arrival: w_rd_ent.arrival,
                               need:    w_rd_ent.need,
                               done:    w_rd_ent.done + LEN_W'(1),
                               service: w_rd_ent.service + LEN_W'(1)};
            r_ent_lvl     <= eff_lvl(w_rd_lvl, w_top);
        end else if (i_cmd.end_slot && w_demote) begin
            r_ent.service <= '0;
        end else if (i_cmd.boost && (r_run_active || r_slice_hit)) begin
            r_ent.service <= '0;
        end
    end

    // record register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((i_cmd.end_slot && (r_fin || r_slice_hit))
                || (i_cmd.boost && r_run_active)) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.end_slot && (r_fin || r_slice_hit)) || (i_cmd.boost && r_run_active)) begin
            o_slot_pid      <= r_ent.pid;
            o_slot_arrival  <= r_ent.arrival;
            o_slot_start    <= r_begin;
            o_slot_end      <= r_now;
            o_slot_level    <= r_ent_lvl;
            o_level_service <= r_ent.service;
            if (i_cmd.boost) begin
                o_left_to_run <= r_ent.need - r_ent.done;
                o_end_cause   <= CAUSE_BOOST;
            end else if (r_fin) begin
                o_left_to_run <= '0;
                o_end_cause   <= CAUSE_DONE;
            end else begin
                o_left_to_run <= r_ent.need - r_ent.done;
                o_end_cause   <= w_demote ? CAUSE_DEMOTE : CAUSE_KEPT;
            end
        end
    end

    // memory ports
    assign w_raddr = i_cmd.ent_rd ? r_run_idx : r_cnt[IDX_W-1:0];

    always_comb begin
        w_ent_we    = 1'b0;
        w_ent_waddr = r_run_idx;
        w_ent_wdata = r_ent;
        if (w_arrive_ok) begin
            w_ent_we            = 1'b1;
            w_ent_waddr         = r_free_idx;
            w_ent_wdata.pid     = r_in_pid;
            w_ent_wdata.arrival = r_now;
            w_ent_wdata.need    = r_in_len;
            w_ent_wdata.done    = '0;
            w_ent_wdata.service = '0;
        end else if (i_cmd.write && r_ent_ld) begin
            w_ent_we = 1'b1;
        end
    end

    always_comb begin
        w_lvl_we    = 1'b0;
        w_lvl_waddr = r_cnt[IDX_W-1:0];
        w_lvl_wdata = w_top;
        if (w_arrive_ok) begin
            w_lvl_we    = 1'b1;
            w_lvl_waddr = r_free_idx;
        end else if (i_cmd.end_slot && w_demote) begin
            w_lvl_we    = 1'b1;
            w_lvl_waddr = r_run_idx;
            w_lvl_wdata = r_ent_lvl - LVL_W'(1);
        end else if (i_cmd.sweep) begin
            w_lvl_we = 1'b1;
        end
    end

    mlfq_ram #(.WIDTH(ENT_W), .DEPTH(TASKS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_raw)
    );

    mlfq_ram #(.WIDTH(LVL_W), .DEPTH(TASKS)) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (w_lvl_we),
        .i_waddr (w_lvl_waddr),
        .i_wdata (w_lvl_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_lvl)
    );

    // shared remainder unit: service mod slice, then time mod boost period
    assign w_dividend = i_cmd.div_slice ? TIME_W'(r_ent.service) : r_now;
    assign w_divisor  = i_cmd.div_slice ? w_slice : r_boost_per;

    mlfq_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_slice || i_cmd.div_boost),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_zero     (w_rem_zero)
    );

    // status to the sequencer
    always_comb begin
        o_sts            = '0;
        o_sts.is_tick    = r_kind;
        o_sts.scan_done  = r_cnt[IDX_W] && !r_lag;
        o_sts.run_active = r_run_active;
        o_sts.fin        = r_fin;
        o_sts.slice_nz   = (w_slice != '0);
        o_sts.div_busy   = w_div_busy;
        o_sts.rem_zero   = w_rem_zero;
        o_sts.rec_due    = r_fin || r_slice_hit;
        o_sts.boost_cand = (r_now != '0) && (r_boost_per != '0);
        o_sts.boost_flag = r_boost_flag;
        o_sts.out_free   = w_out_free;
        o_sts.sweep_last = (r_cnt[IDX_W-1:0] == {IDX_W{1'b1}});
    end
endmodule

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// Top level of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  in        request    i_in_valid / o_in_stall   i_kind, i_task_id, i_run_length
//  out       record     o_out_valid / i_out_stall o_slot_* , o_left_to_run,
//                                                 o_level_service, o_end_cause
//  cfg       write      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  An arrival runs from accept to the next accept in these steps: the accept,
//  a pass over the 64-entry task table (one RAM read per cycle) for
//  duplicate and free-slot search, and the table write.
//  A tick takes the same accept and table pass, pick and read-modify-write of the
//  running entry, up to two waits on the shared serial remainder unit
//  (slice expiry, boost period), on a boost a level sweep of the whole table,
//  and any output stall.
//  Synchronous active-low reset; table contents are not cleared, valid bits are.
//  A record waits in the output register; the next request is taken meanwhile,
//  and the sequencer waits on the output only when a new record meets a full, stalled output register.
module multilevel_feedback_queue_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [mlfq_pkg::PID_W-1:0]          i_task_id,
    input  logic [mlfq_pkg::LEN_W-1:0]          i_run_length,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mlfq_pkg::PID_W-1:0]          o_slot_pid,
    output logic [mlfq_pkg::TIME_W-1:0]         o_slot_arrival,
    output logic [mlfq_pkg::TIME_W-1:0]         o_slot_start,
    output logic [mlfq_pkg::TIME_W-1:0]         o_slot_end,
    output logic [mlfq_pkg::LEN_W-1:0]          o_left_to_run,
    output logic [mlfq_pkg::LVL_W-1:0]          o_slot_level,
    output logic [mlfq_pkg::LEN_W-1:0]          o_level_service,
    output logic [mlfq_pkg::CAUSE_W-1:0]        o_end_cause,
    input  logic                                i_cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mlfq_pkg::CFG_W-1:0]          i_cfg_data
);
    import mlfq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: walks scan, pick, slot accounting, boost and sweep phases
    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: task table RAMs, statistics, remainder unit, record register
    mlfq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_kind),
        .i_task_id       (i_task_id),
        .i_run_length    (i_run_length),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_slot_pid      (o_slot_pid),
        .o_slot_arrival  (o_slot_arrival),
        .o_slot_start    (o_slot_start),
        .o_slot_end      (o_slot_end),
        .o_left_to_run   (o_left_to_run),
        .o_slot_level    (o_slot_level),
        .o_level_service (o_level_service),
        .o_end_cause     (o_end_cause)
    );
endmodule
